/* hdl/hsfc_pkg.sv */
// Package for the half/single float converter.
// Holds request codes and shared constants; no dependencies.
package hsfc_pkg;

  typedef enum logic {
    REQ_S2H = 1'b0,
    REQ_H2S = 1'b1
  } req_type_t;

  localparam logic [15:0] HALF_INF      = 16'h7C00;
  localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
  localparam logic [4:0]  HALF_EXP_MAX  = 5'h1F;

endpackage

/* hdl/hsfc_if.sv */
// Valid/ready channel interfaces for the converter.
// Depends on nothing; request and result channels.
interface hsfc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] operand_bits;
  modport source (output valid, req_type, operand_bits, input ready);
  modport sink (input valid, req_type, operand_bits, output ready);
endinterface

interface hsfc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, result_bits, input ready);
  modport sink (input valid, result_bits, output ready);
endinterface

/* hdl/half_single_float_converter.sv */
// Half/single float converter: three stages, one transfer per unstalled cycle.
// Depends on hsfc_pkg and the channel interfaces in hsfc_if.sv.
//
// Each request converts single to half (req_type 0) or half to single
// (req_type 1); exactly one result follows, in order. A result is offered once
// its request has passed the three register stages, and a new request is
// taken every cycle while the result side accepts: stage 1 finds the position
// of the leading one in the half fraction, stage 2 decodes both formats and
// shifts, stage 3 adds the rounding increment and selects the result. The
// whole pipeline advances whenever its last stage is empty or taken, so a
// stalled result side stalls the input.
module half_single_float_converter (
  input logic clk,
  input logic rst,
  hsfc_req_if.sink   req,
  hsfc_res_if.source res
);
  import hsfc_pkg::*;

  logic advance;
  logic v1, v2, v3;

  // Stage 1 registers.
  logic        t1;
  logic [31:0] op1;
  logic [3:0]  p1;
  logic [3:0]  p_next;

  // Stage 2 registers.
  logic        t2;
  logic [15:0] s2h_base;
  logic        s2h_round;
  logic [31:0] h2s_res;

  // Stage 3 register.
  logic [31:0] out3;

  assign advance = !v3 || res.ready;
  assign req.ready = advance;
  assign res.valid = v3;
  assign res.result_bits = out3;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: position of the leading one in the half fraction.
  always_comb begin
    p_next = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (req.operand_bits[i]) p_next = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1  <= req.req_type;
      op1 <= req.operand_bits;
      p1  <= p_next;
    end
  end

  // Stage 2 combinational work: both directions computed.
  logic [7:0]  se;
  logic [22:0] sf;
  logic [4:0]  ee;
  logic [7:0]  shift;
  logic [23:0] mant;
  logic [15:0] b_next;
  logic        rb_next;
  logic [4:0]  he;
  logic [9:0]  hf;
  logic [7:0]  hexp;
  logic [9:0]  hfrac;

  always_comb begin
    se = op1[30:23];
    sf = op1[22:0];
    ee = 5'(se - 8'd112);
    shift = 8'd126 - se;
    mant = {1'b1, sf};
    b_next = 16'h0000;
    rb_next = 1'b0;
    if (se == 8'd0) begin
      b_next = {op1[31], 15'd0};
    end else if (se == SINGLE_EXP_MAX) begin
      if (sf == 23'd0) b_next = {op1[31], 15'd0} | HALF_INF;
      else b_next = {6'd0, sf[22:13]} | HALF_INF;
    end else if (se >= 8'd143) begin
      b_next = {op1[31], 15'd0} | HALF_INF;
    end else if (se <= 8'd112) begin
      if (shift > 8'd24) begin
        b_next = {op1[31], 15'd0};
      end else begin
        b_next = {op1[31], 15'd0} | 16'(mant >> shift[4:0]);
        rb_next = mant[5'(shift[4:0] - 5'd1)];
      end
    end else begin
      b_next = {op1[31], ee, sf[22:13]};
      rb_next = sf[12];
    end
  end

  always_comb begin
    he = op1[14:10];
    hf = op1[9:0];
    hexp = {3'd0, he} + 8'd112;
    hfrac = hf;
    if (he == 5'd0) begin
      if (hf != 10'd0) begin
        hexp = 8'd103 + {4'd0, p1};
        hfrac = hf << (4'd10 - p1);
      end else begin
        hexp = 8'd0;
      end
    end else if (he == HALF_EXP_MAX) begin
      hexp = SINGLE_EXP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t2 <= t1;
      s2h_base <= b_next;
      s2h_round <= rb_next;
      h2s_res <= {op1[15], hexp, hfrac, 13'd0};
    end
  end

  // Stage 3: rounding increment and result select.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (t2 == REQ_H2S) out3 <= h2s_res;
      else out3 <= {16'd0, s2h_base + {15'd0, s2h_round}};
    end
  end

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    v3 && !res.ready |=> v3 && $stable(out3))
    else $error("result changed while stalled");
  a_half_upper: assert property (@(posedge clk) disable iff (rst)
    advance && v2 && t2 == REQ_S2H |=> out3[31:16] == 16'd0)
    else $error("half result has upper bits set");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    advance && v2 |=> v3)
    else $error("item lost between stages");
endmodule
